// ===== design/fgc_pkg.sv =====
`timescale 1ns / 1ps

package fgc_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_INNER = 256;
  localparam int MAX_ROWS  = 4096;

  localparam logic [63:0] FIELD_PRIME = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] EPS         = 64'h0000_0000_FFFF_FFFF;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int INR_W = $clog2(MAX_INNER);
  localparam int ROW_W = $clog2(MAX_ROWS);

  localparam logic [1:0] OP_CHAL = 2'd0;
  localparam logic [1:0] OP_B    = 2'd1;
  localparam logic [1:0] OP_A    = 2'd2;
  localparam logic [1:0] OP_Y    = 2'd3;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  typedef enum logic [3:0] {
    PH_CHAL = 4'b0001,
    PH_B    = 4'b0010,
    PH_A    = 4'b0100,
    PH_Y    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic             seqerr;
    logic             seg_end;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [INR_W-1:0] kaddr;
  } side_t;

  function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, FIELD_PRIME}) s = s - {1'b0, FIELD_PRIME};
    return s[63:0];
  endfunction

endpackage

// ===== design/fgc_ram.sv =====
`timescale 1ns / 1ps

module fgc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== design/fgc_mulmod.sv =====
`timescale 1ns / 1ps

module fgc_mulmod (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fgc_pkg::side_t side_in,
  input  logic [63:0]    a_in,
  input  logic [63:0]    b_in,
  output fgc_pkg::side_t side_out,
  output logic [63:0]    prod,
  output logic           b_busy
);

  fgc_pkg::side_t s0, s1, s2, s3;
  logic [63:0]  a0;
  logic [63:0]  pp0, pp1, pp2, pp3;
  logic [127:0] x;
  logic [63:0]  t0, u;
  logic [64:0]  d, s;
  logic [63:0]  r;
  logic [127:0] x_next;

  always_comb begin
    x_next = {64'd0, pp0} + {31'd0, ({1'b0, pp1} + {1'b0, pp2}), 32'd0} + {pp3, 64'd0};
    d = {1'b0, x[63:0]} - {33'd0, x[127:96]};
    s = {1'b0, t0} + {1'b0, u};
    r = s[64] ? s[63:0] + fgc_pkg::EPS : s[63:0];
    if (r >= fgc_pkg::FIELD_PRIME) r = r - fgc_pkg::FIELD_PRIME;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= '0;
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      side_out <= '0;
    end else if (en) begin
      s0 <= side_in;
      s1 <= s0;
      s2 <= s1;
      s3 <= s2;
      side_out <= s3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= a_in;
      pp0 <= a0[31:0]  * b_in[31:0];
      pp1 <= a0[31:0]  * b_in[63:32];
      pp2 <= a0[63:32] * b_in[31:0];
      pp3 <= a0[63:32] * b_in[63:32];
      x   <= x_next;
      t0  <= d[64] ? d[63:0] - fgc_pkg::EPS : d[63:0];
      u   <= {x[95:64], 32'd0} - {32'd0, x[95:64]};
      prod <= r;
    end
  end

  assign b_busy = (s0.valid && s0.kind == fgc_pkg::OP_B) || (s1.valid && s1.kind == fgc_pkg::OP_B)
               || (s2.valid && s2.kind == fgc_pkg::OP_B) || (s3.valid && s3.kind == fgc_pkg::OP_B)
               || (side_out.valid && side_out.kind == fgc_pkg::OP_B);

endmodule

// ===== design/freivalds_gemm_check.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    op, challenge, entry
// out      out_valid / out_ready  row_index, row_ok, any_failed, last_row, sequence_error
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless the output stalls or an A beat waits for B; a result passes
// through the RAM read, four multiply/reduce stages and the accumulate into the output register.
// The first A beat of a repetition waits until the last B projection is written back.
// Reset is synchronous; RAM contents are not cleared. cfg_ready is always high.
// A stalled output holds the whole pipeline.
module freivalds_gemm_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] challenge,
  input  logic signed [63:0] entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] row_index,
  output logic        row_ok,
  output logic        any_failed,
  output logic        last_row,
  output logic        sequence_error
);

  logic [12:0] rows_m;
  logic [8:0]  inner_k, cols_n;
  logic [12:0] m;
  logic [8:0]  k, n;

  fgc_pkg::phase_t phase;
  logic [fgc_pkg::COL_W-1:0] column_count;
  logic [fgc_pkg::INR_W-1:0] inner_count;
  logic [fgc_pkg::ROW_W-1:0] row_count;

  logic [63:0] row_sum, lhs_sum, rhs_sum;
  logic        failed;

  logic        en, accept, op_ok, col_end, inr_end, row_end;
  logic [1:0]  phase_op;
  logic [63:0] chal_red, ent_f;
  fgc_pkg::side_t side_in, side_out;
  logic [63:0] chal_rd, proj_rd, b_sel, prod;
  logic        b_busy;
  logic [63:0] acc_new;
  logic        ok, fnew;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en && !(phase == fgc_pkg::PH_A && b_busy);
  assign accept    = in_valid && in_ready;

  always_comb begin
    m = (rows_m == 13'd0) ? 13'd1 : (rows_m > 13'(fgc_pkg::MAX_ROWS) ? 13'(fgc_pkg::MAX_ROWS) : rows_m);
    k = (inner_k == 9'd0) ? 9'd1 : (inner_k > 9'(fgc_pkg::MAX_INNER) ? 9'(fgc_pkg::MAX_INNER) : inner_k);
    n = (cols_n == 9'd0) ? 9'd1 : (cols_n > 9'(fgc_pkg::MAX_COLS) ? 9'(fgc_pkg::MAX_COLS) : cols_n);
    unique case (phase)
      fgc_pkg::PH_CHAL: phase_op = fgc_pkg::OP_CHAL;
      fgc_pkg::PH_B:    phase_op = fgc_pkg::OP_B;
      fgc_pkg::PH_A:    phase_op = fgc_pkg::OP_A;
      fgc_pkg::PH_Y:    phase_op = fgc_pkg::OP_Y;
      default:          phase_op = fgc_pkg::OP_CHAL;
    endcase
    op_ok   = (op == phase_op);
    col_end = ({1'b0, column_count} + 9'd1) >= n;
    inr_end = ({1'b0, inner_count} + 9'd1) >= k;
    row_end = ({1'b0, row_count} + 13'd1) >= m;
    chal_red = (challenge >= fgc_pkg::FIELD_PRIME) ? challenge - fgc_pkg::FIELD_PRIME : challenge;
    ent_f    = entry[63] ? entry - fgc_pkg::EPS : entry;
    side_in.valid   = accept;
    side_in.kind    = op;
    side_in.seqerr  = !op_ok;
    side_in.seg_end = col_end;
    side_in.last    = row_end;
    side_in.row     = row_count;
    side_in.kaddr   = inner_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= 13'd1;
      inner_k <= 9'd1;
      cols_n  <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fgc_pkg::REG_ROWS:  rows_m  <= cfg_data;
        fgc_pkg::REG_INNER: inner_k <= cfg_data[8:0];
        fgc_pkg::REG_COLS:  cols_n  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fgc_pkg::PH_CHAL;
      column_count <= '0;
      inner_count  <= '0;
      row_count    <= '0;
    end else if (accept && op_ok) begin
      unique case (phase)
        fgc_pkg::PH_CHAL: begin
          if (col_end) begin
            column_count <= '0;
            phase <= fgc_pkg::PH_B;
          end else column_count <= column_count + 1'b1;
        end
        fgc_pkg::PH_B: begin
          if (col_end) begin
            column_count <= '0;
            if (inr_end) begin
              inner_count <= '0;
              phase <= fgc_pkg::PH_A;
            end else inner_count <= inner_count + 1'b1;
          end else column_count <= column_count + 1'b1;
        end
        fgc_pkg::PH_A: begin
          if (inr_end) begin
            inner_count <= '0;
            phase <= fgc_pkg::PH_Y;
          end else inner_count <= inner_count + 1'b1;
        end
        fgc_pkg::PH_Y: begin
          if (col_end) begin
            column_count <= '0;
            if (row_end) begin
              row_count <= '0;
              phase <= fgc_pkg::PH_CHAL;
            end else begin
              row_count <= row_count + 1'b1;
              phase <= fgc_pkg::PH_A;
            end
          end else column_count <= column_count + 1'b1;
        end
        default: phase <= fgc_pkg::PH_CHAL;
      endcase
    end
  end

  fgc_ram #(.WIDTH(64), .DEPTH(fgc_pkg::MAX_COLS)) u_chal_ram (
    .clk   (clk),
    .we    (accept && op_ok && phase == fgc_pkg::PH_CHAL),
    .waddr (column_count),
    .wdata (chal_red),
    .re    (accept),
    .raddr (column_count),
    .rdata (chal_rd)
  );

  fgc_ram #(.WIDTH(64), .DEPTH(fgc_pkg::MAX_INNER)) u_proj_ram (
    .clk   (clk),
    .we    (en && side_out.valid && !side_out.seqerr && side_out.kind == fgc_pkg::OP_B
            && side_out.seg_end),
    .waddr (side_out.kaddr),
    .wdata (acc_new),
    .re    (accept),
    .raddr (inner_count),
    .rdata (proj_rd)
  );

  fgc_mulmod u_mulmod (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (side_in),
    .a_in     (ent_f),
    .b_in     (b_sel),
    .side_out (side_out),
    .prod     (prod),
    .b_busy   (b_busy)
  );

  // operand select follows the item one stage after accept
  fgc_pkg::side_t s0_side;
  always_ff @(posedge clk) begin
    if (en) s0_side <= side_in;
  end
  assign b_sel = (s0_side.kind == fgc_pkg::OP_A) ? proj_rd : chal_rd;

  always_comb begin
    case (side_out.kind)
      fgc_pkg::OP_B: acc_new = fgc_pkg::fadd(row_sum, prod);
      fgc_pkg::OP_A: acc_new = fgc_pkg::fadd(lhs_sum, prod);
      default:       acc_new = fgc_pkg::fadd(rhs_sum, prod);
    endcase
    ok   = (lhs_sum == acc_new);
    fnew = failed || !ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum   <= '0;
      lhs_sum   <= '0;
      rhs_sum   <= '0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= 1'b0;
      if (side_out.valid && side_out.seqerr) begin
        out_valid      <= 1'b1;
        row_index      <= side_out.row;
        row_ok         <= 1'b0;
        any_failed     <= failed;
        last_row       <= 1'b0;
        sequence_error <= 1'b1;
      end else if (side_out.valid) begin
        case (side_out.kind)
          fgc_pkg::OP_B: row_sum <= side_out.seg_end ? 64'd0 : acc_new;
          fgc_pkg::OP_A: lhs_sum <= acc_new;
          fgc_pkg::OP_Y: begin
            if (side_out.seg_end) begin
              out_valid      <= 1'b1;
              row_index      <= side_out.row;
              row_ok         <= ok;
              any_failed     <= fnew;
              last_row       <= side_out.last;
              sequence_error <= 1'b0;
              lhs_sum        <= '0;
              rhs_sum        <= '0;
              failed         <= side_out.last ? 1'b0 : fnew;
            end else rhs_sum <= acc_new;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== dv/freivalds_gemm_check_tb.sv =====
`timescale 1ns / 1ps

module freivalds_gemm_check_tb;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] chal;
    logic [63:0] ent;
  } beat_t;

  typedef struct {
    logic [11:0] row;
    logic        ok;
    logic        failed;
    logic        last;
    logic        seqerr;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [63:0] challenge = '0;
  logic signed [63:0] entry = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [11:0] row_index;
  logic row_ok, any_failed, last_row, sequence_error;

  beat_t pending_beats[$];
  verdict_t verdicts_due[$];
  int errors = 0;
  int send_idle = 19;
  int recv_idle = 61;
  logic send_hold = 1'b0;
  logic recv_hold = 1'b0;
  int stall_cycles = 0;

  // model state
  logic [63:0] chal_mem[fgc_pkg::MAX_COLS];
  logic [63:0] proj_mem[fgc_pkg::MAX_INNER];
  logic [63:0] acc_row, acc_lhs, acc_rhs;
  logic [1:0]  cur_phase;
  int col_cnt, inr_cnt, row_cnt;
  logic fail_flag;
  logic [12:0] reg_rows, reg_inner, reg_cols;

  freivalds_gemm_check DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] gf_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, fgc_pkg::FIELD_PRIME}) s = s - {1'b0, fgc_pkg::FIELD_PRIME};
    return s[63:0];
  endfunction

  function automatic logic [63:0] gf_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p % {64'd0, fgc_pkg::FIELD_PRIME};
    return p[63:0];
  endfunction

  function automatic logic [63:0] to_field(logic [63:0] v);
    logic [63:0] m;
    if (!v[63]) return v % fgc_pkg::FIELD_PRIME;
    m = (~v + 64'd1) % fgc_pkg::FIELD_PRIME;
    return (m == 0) ? 64'd0 : fgc_pkg::FIELD_PRIME - m;
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic predict_beat(logic [1:0] bop, logic [63:0] bchal, logic [63:0] bent);
    int n, k, m;
    logic [63:0] e;
    verdict_t v;
    n = clip(reg_cols, fgc_pkg::MAX_COLS);
    k = clip(reg_inner, fgc_pkg::MAX_INNER);
    m = clip(reg_rows, fgc_pkg::MAX_ROWS);
    e = to_field(bent);
    if (bop != cur_phase) begin
      v.row = row_cnt[11:0]; v.ok = 0; v.failed = fail_flag; v.last = 0; v.seqerr = 1;
      verdicts_due.push_back(v);
      return;
    end
    case (cur_phase)
      fgc_pkg::OP_CHAL: begin
        chal_mem[col_cnt % fgc_pkg::MAX_COLS] = bchal % fgc_pkg::FIELD_PRIME;
        if (col_cnt + 1 >= n) begin col_cnt = 0; cur_phase = fgc_pkg::OP_B; end
        else col_cnt++;
      end
      fgc_pkg::OP_B: begin
        acc_row = gf_add(acc_row, gf_mul(e, chal_mem[col_cnt % fgc_pkg::MAX_COLS]));
        if (col_cnt + 1 >= n) begin
          col_cnt = 0;
          proj_mem[inr_cnt % fgc_pkg::MAX_INNER] = acc_row;
          acc_row = 0;
          if (inr_cnt + 1 >= k) begin inr_cnt = 0; cur_phase = fgc_pkg::OP_A; end
          else inr_cnt++;
        end else col_cnt++;
      end
      fgc_pkg::OP_A: begin
        acc_lhs = gf_add(acc_lhs, gf_mul(e, proj_mem[inr_cnt % fgc_pkg::MAX_INNER]));
        if (inr_cnt + 1 >= k) begin inr_cnt = 0; cur_phase = fgc_pkg::OP_Y; end
        else inr_cnt++;
      end
      default: begin
        acc_rhs = gf_add(acc_rhs, gf_mul(e, chal_mem[col_cnt % fgc_pkg::MAX_COLS]));
        if (col_cnt + 1 < n) col_cnt++;
        else begin
          v.ok = (acc_lhs == acc_rhs);
          v.last = (row_cnt + 1 >= m);
          if (!v.ok) fail_flag = 1;
          v.row = row_cnt[11:0]; v.failed = fail_flag; v.seqerr = 0;
          verdicts_due.push_back(v);
          col_cnt = 0; acc_lhs = 0; acc_rhs = 0;
          if (v.last) begin row_cnt = 0; fail_flag = 0; cur_phase = fgc_pkg::OP_CHAL; end
          else begin row_cnt++; cur_phase = fgc_pkg::OP_A; end
        end
      end
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_beat(op, challenge, entry);
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && !send_hold && $urandom_range(99) >= send_idle) begin
          b = pending_beats.pop_front();
          in_valid <= 1'b1;
          op <= b.op;
          challenge <= b.chal;
          entry <= b.ent;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          report("unexpected beat", row_index, 0);
        end else begin
          w = verdicts_due.pop_front();
          if (row_index !== w.row) report("row_index", row_index, w.row);
          if (row_ok !== w.ok) report("row_ok", row_ok, w.ok);
          if (any_failed !== w.failed) report("any_failed", any_failed, w.failed);
          if (last_row !== w.last) report("last_row", last_row, w.last);
          if (sequence_error !== w.seqerr) report("sequence_error", sequence_error, w.seqerr);
        end
      end
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 20000) begin
      $display("timeout at %0t", $realtime);
      $display("freivalds_gemm_check_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == fgc_pkg::REG_ROWS) reg_rows = data;
    else if (idx == fgc_pkg::REG_INNER) reg_inner = data & 13'h1FF;
    else reg_cols = data & 13'h1FF;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || verdicts_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic hold_receiver(int cycles);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
  endtask

  task automatic push(logic [1:0] want_op, logic [63:0] c, logic [63:0] e, int noise);
    beat_t b;
    if ($urandom_range(99) < noise) begin
      b.op = (want_op + 2'($urandom_range(1, 3)));
      b.chal = {$urandom, $urandom};
      b.ent = {$urandom, $urandom};
      pending_beats.push_back(b);
    end
    b.op = want_op; b.chal = c; b.ent = e;
    pending_beats.push_back(b);
  endtask

  function automatic longint pick_small(bit edgy);
    int s;
    if (edgy) begin
      s = $urandom_range(5);
      case (s)
        0: return -128;
        1: return 127;
        2: return 0;
        3: return -1;
        4: return 64'sh8000_0000_0000_0000;
        default: return 64'sh7FFF_FFFF_FFFF_FFFF;
      endcase
    end
    if ($urandom_range(49) == 0) return {$urandom, $urandom};
    return longint'(byte'($urandom_range(255)));
  endfunction

  function automatic logic [63:0] pick_chal(bit edgy);
    if (edgy || $urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: return 64'd0;
        1: return '1;
        2: return fgc_pkg::FIELD_PRIME;
        3: return fgc_pkg::FIELD_PRIME - 1;
        default: return fgc_pkg::FIELD_PRIME + $urandom_range(100);
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  task automatic run_set(int rm, int rk, int rn, int noise, bit edgy);
    int m, k, n;
    longint bmat[int];
    longint arow[int];
    longint y;
    m = clip(rm, fgc_pkg::MAX_ROWS);
    k = clip(rk, fgc_pkg::MAX_INNER);
    n = clip(rn, fgc_pkg::MAX_COLS);
    drain();
    write_reg(fgc_pkg::REG_ROWS, 13'(rm));
    write_reg(fgc_pkg::REG_INNER, 13'(rk));
    write_reg(fgc_pkg::REG_COLS, 13'(rn));
    for (int j = 0; j < n; j++)
      push(fgc_pkg::OP_CHAL, pick_chal(edgy), {$urandom, $urandom}, noise);
    for (int t = 0; t < k; t++)
      for (int j = 0; j < n; j++) begin
        bmat[t * 256 + j] = pick_small(edgy);
        push(fgc_pkg::OP_B, {$urandom, $urandom}, bmat[t * 256 + j], noise);
      end
    for (int i = 0; i < m; i++) begin
      for (int t = 0; t < k; t++) begin
        arow[t] = pick_small(edgy);
        push(fgc_pkg::OP_A, {$urandom, $urandom}, arow[t], noise);
      end
      for (int j = 0; j < n; j++) begin
        y = 0;
        for (int t = 0; t < k; t++) y += arow[t] * bmat[t * 256 + j];
        if ($urandom_range(15) == 0) y += $urandom_range(1, 1000);
        if (edgy && $urandom_range(3) == 0) y = {$urandom, $urandom};
        push(fgc_pkg::OP_Y, {$urandom, $urandom}, y, noise);
      end
    end
  endtask

  initial begin
    beat_t b;
    acc_row = 0; acc_lhs = 0; acc_rhs = 0;
    cur_phase = fgc_pkg::OP_CHAL;
    col_cnt = 0; inr_cnt = 0; row_cnt = 0;
    fail_flag = 0;
    reg_rows = 1; reg_inner = 1; reg_cols = 1;
    foreach (chal_mem[i]) chal_mem[i] = 0;
    foreach (proj_mem[i]) proj_mem[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    b.op = fgc_pkg::OP_Y; b.chal = '1; b.ent = '1;
    pending_beats.push_back(b);
    b.op = fgc_pkg::OP_A; b.chal = 0; b.ent = 0;
    pending_beats.push_back(b);
    run_set(0, 0, 0, 50, 1);
    run_set(2, 2, 2, 40, 1);
    run_set(3, 1, 2, 0, 0);
    hold_receiver(400);
    run_set(1, 511, 1, 2, 0);
    run_set(1, 1, 511, 2, 0);
    drain();

    for (int r = 0; r < 40; r++) begin
      if (r == 13) begin send_idle = 61; recv_idle = 19; end
      if (r == 26) begin send_idle = 0; recv_idle = 0; end
      if ($urandom_range(19) == 0)
        run_set($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16), 5, 0);
      else
        run_set($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                $urandom_range(0, 10), $urandom_range(9) == 0);
      if (r == 20) hold_receiver(300);
    end
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("freivalds_gemm_check_tb: done, clean");
    else
      $display("freivalds_gemm_check_tb: done, errors");
    $finish;
  end

endmodule
